// ----- rtl/core/bbsp_pkg.sv -----
package bbsp_pkg;

    localparam int BUFFER_BYTES_DEF = 256;
    localparam int CFG_W            = 9;
    localparam int VALUE_W          = 64;
    localparam int CNT_W            = 4;
    localparam int BYTE_W           = 8;
    localparam int IDX_W            = 8;
    localparam int SEL_W            = 3;
    localparam int N_W              = 4;

    localparam logic [CFG_W-1:0] CAP_RESET = 9'd256;
    localparam logic [CNT_W-1:0] MAX_COUNT = 4'd8;

    typedef enum logic
    {
        OP_BITS  = 1'b0,
        OP_BYTES = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        ST_OK    = 2'd0,
        ST_COUNT = 2'd1,
        ST_FULL  = 2'd2,
        ST_ALIGN = 2'd3
    } status_t;

    typedef enum logic
    {
        S_IDLE = 1'b0,
        S_EMIT = 1'b1
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed
    {
        logic accept;
        logic emit;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed
    {
        logic slot_free;
        logic final_result;
    } dp_stat_t;

endpackage

// ----- rtl/core/bbsp_ctrl.sv -----
module bbsp_ctrl
    import bbsp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // leave once the final word is loaded into the output stage
                if (stat.slot_free && stat.final_result)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.emit   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            S_EMIT:
            begin
                cmd.emit = stat.slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_accept_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (state_reg == S_EMIT))
        else $error("accepted word did not start emission");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.accept && cmd.emit))
        else $error("accept and emit in the same cycle");

    a_leave_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && !stat.final_result) |=> (state_reg == S_EMIT))
        else $error("emission stopped before final result");
`endif

endmodule

// ----- rtl/core/bbsp_dp.sv -----
module bbsp_dp
    import bbsp_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CFG_W-1:0]   cfg_data,
    input  ctrl_cmd_t          cmd,
    output dp_stat_t           stat,
    input  logic               opcode,
    input  logic [VALUE_W-1:0] value,
    input  logic [CNT_W-1:0]   item_count,
    input  logic               little_endian,
    input  logic               out_ready,
    output logic               out_valid,
    output logic               write_valid,
    output logic [IDX_W-1:0]   byte_index,
    output logic [BYTE_W-1:0]  byte_value,
    output logic [1:0]         status,
    output logic               last
);

    localparam int PTR_W = $clog2(BUFFER_BYTES + 1);
    localparam int CMP_W = (PTR_W > CFG_W) ? PTR_W : CFG_W;

    // position state: bytes past the pointer are still clear, so only the
    // byte under the pointer needs holding
    logic [CFG_W-1:0]   cap_reg;
    logic [PTR_W-1:0]   byte_ptr_reg, byte_ptr_next;
    logic [2:0]         bit_ptr_reg, bit_ptr_next;
    logic [BYTE_W-1:0]  partial_reg, partial_next;

    // item held for emission
    logic [VALUE_W-1:0] value_reg;
    logic               bytes_mode_reg;
    logic               rev_reg;
    logic [SEL_W-1:0]   sel_reg;
    logic [N_W-1:0]     n_reg, n_next;
    logic [SEL_W-1:0]   k_reg;
    logic               wr_reg, wr_next;
    status_t            st_reg, st_next;
    logic [IDX_W-1:0]   base_reg;
    logic [BYTE_W-1:0]  first_reg, first_next;
    logic [BYTE_W-1:0]  second_reg, second_next;

    // output stage
    logic               out_valid_reg;
    logic               out_wr_reg;
    logic [IDX_W-1:0]   out_idx_reg;
    logic [BYTE_W-1:0]  out_val_reg;
    status_t            out_st_reg;
    logic               out_last_reg;

    logic [CMP_W-1:0]   cap_c;
    logic [CMP_W-1:0]   ptr_c;
    logic [CMP_W-1:0]   room;
    logic               at_cap;
    logic               second_room;
    logic [4:0]         bit_total;
    logic [BYTE_W-1:0]  low_mask;
    logic [2*BYTE_W-1:0] spread;
    logic [CNT_W-1:0]   n_bytes;
    logic               rev;
    logic               final_result;
    logic [BYTE_W-1:0]  emit_val;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cap_c = (CMP_W'(cap_reg) > CMP_W'(BUFFER_BYTES)) ? CMP_W'(BUFFER_BYTES)
                                                         : CMP_W'(cap_reg);
        ptr_c       = CMP_W'(byte_ptr_reg);
        room        = cap_c - ptr_c;
        at_cap      = (ptr_c >= cap_c);
        second_room = ((ptr_c + CMP_W'(1)) < cap_c);
        bit_total   = 5'(bit_ptr_reg) + 5'(item_count);
        low_mask    = ~(8'hFF << item_count);
        spread      = {8'h00, value[BYTE_W-1:0] & low_mask} << bit_ptr_reg;
        n_bytes     = (CMP_W'(item_count) > room) ? CNT_W'(room) : item_count;
        rev         = little_endian && ((item_count == 4'd1) || (item_count == 4'd2) ||
                                        (item_count == 4'd4) || (item_count == MAX_COUNT));
    end

    // plan the item and move the position at accept
    always_comb
    begin
        byte_ptr_next = byte_ptr_reg;
        bit_ptr_next  = bit_ptr_reg;
        partial_next  = partial_reg;
        n_next        = N_W'(1);
        wr_next       = 1'b0;
        st_next       = ST_OK;
        first_next    = partial_reg | spread[BYTE_W-1:0];
        second_next   = spread[2*BYTE_W-1:BYTE_W];
        if (item_count > MAX_COUNT)
        begin
            st_next = ST_COUNT;
        end
        else if (item_count != '0)
        begin
            if (opcode == OP_BITS)
            begin
                if (at_cap)
                begin
                    st_next = ST_FULL;
                end
                else
                begin
                    wr_next = 1'b1;
                    if (bit_total > 5'd8)
                    begin
                        byte_ptr_next = byte_ptr_reg + PTR_W'(1);
                        if (second_room)
                        begin
                            n_next       = N_W'(2);
                            bit_ptr_next = bit_total[2:0];
                            partial_next = second_next;
                        end
                        else
                        begin
                            st_next      = ST_FULL;
                            bit_ptr_next = 3'd0;
                            partial_next = '0;
                        end
                    end
                    else if (bit_total == 5'd8)
                    begin
                        byte_ptr_next = byte_ptr_reg + PTR_W'(1);
                        bit_ptr_next  = 3'd0;
                        partial_next  = '0;
                    end
                    else
                    begin
                        bit_ptr_next = bit_total[2:0];
                        partial_next = first_next;
                    end
                end
            end
            else
            begin
                if (at_cap)
                begin
                    st_next = ST_FULL;
                end
                else if (bit_ptr_reg != 3'd0)
                begin
                    st_next = ST_ALIGN;
                end
                else
                begin
                    wr_next       = 1'b1;
                    n_next        = N_W'(n_bytes);
                    byte_ptr_next = byte_ptr_reg + PTR_W'(n_bytes);
                    if (n_bytes != item_count)
                    begin
                        st_next = ST_FULL;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg      <= CAP_RESET;
            byte_ptr_reg <= '0;
            bit_ptr_reg  <= '0;
            partial_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
            if (cmd.accept)
            begin
                byte_ptr_reg <= byte_ptr_next;
                bit_ptr_reg  <= bit_ptr_next;
                partial_reg  <= partial_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            value_reg      <= value;
            bytes_mode_reg <= (opcode == OP_BYTES);
            rev_reg        <= rev;
            sel_reg        <= rev ? '0 : SEL_W'(item_count - 4'd1);
            n_reg          <= n_next;
            wr_reg         <= wr_next;
            st_reg         <= st_next;
            base_reg       <= IDX_W'(byte_ptr_reg);
            first_reg      <= first_next;
            second_reg     <= second_next;
        end
        else if (cmd.emit)
        begin
            sel_reg <= rev_reg ? sel_reg + SEL_W'(1) : sel_reg - SEL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= '0;
        end
        else if (cmd.accept)
        begin
            k_reg <= '0;
        end
        else if (cmd.emit)
        begin
            k_reg <= k_reg + SEL_W'(1);
        end
    end

    assign final_result = ((N_W'(k_reg) + N_W'(1)) == n_reg);

    always_comb
    begin
        if (!wr_reg)
        begin
            emit_val = '0;
        end
        else if (bytes_mode_reg)
        begin
            emit_val = value_reg[{sel_reg, 3'b000} +: BYTE_W];
        end
        else
        begin
            emit_val = (k_reg == '0) ? first_reg : second_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_wr_reg   <= wr_reg;
            out_idx_reg  <= wr_reg ? base_reg + IDX_W'(k_reg) : '0;
            out_val_reg  <= emit_val;
            out_st_reg   <= final_result ? st_reg : ST_OK;
            out_last_reg <= final_result;
        end
    end

    assign stat.slot_free    = !out_valid_reg || out_ready;
    assign stat.final_result = final_result;

    assign out_valid   = out_valid_reg;
    assign write_valid = out_wr_reg;
    assign byte_index  = out_idx_reg;
    assign byte_value  = out_val_reg;
    assign status      = out_st_reg;
    assign last        = out_last_reg;

`ifndef NO_ASSERTIONS
    a_aligned_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (bit_ptr_reg == 3'd0) |-> (partial_reg == '0))
        else $error("held byte not clear at byte boundary");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(byte_ptr_reg) <= CMP_W'(BUFFER_BYTES))
        else $error("byte pointer beyond buffer");

    a_bits_two_max: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && !bytes_mode_reg) |-> (n_reg <= N_W'(2)))
        else $error("bits item planned more than two words");

    a_status_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |-> (out_st_reg == ST_OK))
        else $error("status on a non-final word");
`endif

endmodule

// ----- rtl/core/bit_byte_stream_packer_top.sv -----
// After an input word is accepted, the controller enters its emit state and the output register
// loads the first result word when the output slot is free; an item gives n = 1..8 result words,
// and the output register loads one result word per cycle while the output slot is free.
// Input is accepted again in the cycle after the last result word is loaded.
// Reset (rst_n low, asynchronous): buffer position and held byte cleared,
// capacity_bytes set to 256, no word pending.
module bit_byte_stream_packer_top
    import bbsp_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CFG_W-1:0]   cfg_data,      // capacity_bytes
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [71:0]        s_axis_tdata,  // value[63:0], item_count[67:64], zero pad
    input  logic [1:0]         s_axis_tuser,  // opcode[0], little_endian[1]
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [15:0]        m_axis_tdata,  // byte_index[7:0], byte_value[15:8]
    output logic [2:0]         m_axis_tuser,  // write_valid[0], status[2:1]
    output logic               m_axis_tlast
);

    ctrl_cmd_t          cmd;
    dp_stat_t           stat;
    logic               write_valid;
    logic [IDX_W-1:0]   byte_index;
    logic [BYTE_W-1:0]  byte_value;
    logic [1:0]         status;

    bbsp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bbsp_dp #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .stat          (stat),
        .opcode        (s_axis_tuser[0]),
        .value         (s_axis_tdata[VALUE_W-1:0]),
        .item_count    (s_axis_tdata[VALUE_W +: CNT_W]),
        .little_endian (s_axis_tuser[1]),
        .out_ready     (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .write_valid   (write_valid),
        .byte_index    (byte_index),
        .byte_value    (byte_value),
        .status        (status),
        .last          (m_axis_tlast)
    );

    assign m_axis_tdata = {byte_value, byte_index};
    assign m_axis_tuser = {status, write_valid};

endmodule

// ----- test/tb_bit_byte_stream_packer_top.sv -----
`timescale 1ns / 1ps

import bbsp_pkg::*;

typedef struct
{
    bit          write_valid;
    logic [7:0]  byte_index;
    logic [7:0]  byte_value;
    status_t     status;
    bit          last;
} write_word_t;

class byte_write_tracker;
    logic [7:0]   image [BUFFER_BYTES_DEF];
    int unsigned  byte_ptr;
    int unsigned  bit_ptr;
    int unsigned  capacity;
    write_word_t  pending_writes [$];
    int unsigned  errors;

    function new();
        foreach (image[i])
            image[i] = '0;
        byte_ptr = 0;
        bit_ptr  = 0;
        capacity = CAP_RESET;
        errors   = 0;
    endfunction

    // Apply one accepted input word to the buffer image and queue the words it should produce
    function void predict_writes(opcode_t op, logic [63:0] value, int unsigned cnt, bit le);
        int unsigned  limit;
        int unsigned  touched [$];
        write_word_t  words [$];
        write_word_t  w;
        status_t      st;
        bit           reverse;
        int unsigned  sh;
        int unsigned  t;
        limit = (capacity < BUFFER_BYTES_DEF) ? capacity : BUFFER_BYTES_DEF;
        st    = ST_OK;
        if (cnt > MAX_COUNT)
            st = ST_COUNT;
        else if (op == OP_BITS)
        begin
            for (t = 0; t < cnt; t++)
            begin
                if (byte_ptr >= limit)
                begin
                    st = ST_FULL;
                    break;
                end
                if (value[t])
                    image[byte_ptr][bit_ptr] = 1'b1;
                if (touched.size() == 0 || touched[touched.size() - 1] != byte_ptr)
                    touched.push_back(byte_ptr);
                bit_ptr++;
                if (bit_ptr == 8)
                begin
                    bit_ptr = 0;
                    byte_ptr++;
                end
            end
        end
        else if (cnt != 0)
        begin
            if (byte_ptr >= limit)
                st = ST_FULL;
            else if (bit_ptr != 0)
                st = ST_ALIGN;
            else
            begin
                // little-endian order only for power-of-two counts
                reverse = le && (cnt == 1 || cnt == 2 || cnt == 4 || cnt == 8);
                for (t = 0; t < cnt; t++)
                begin
                    if (byte_ptr >= limit)
                    begin
                        st = ST_FULL;
                        break;
                    end
                    sh = reverse ? 8 * t : 8 * (cnt - 1 - t);
                    image[byte_ptr] = 8'(value >> sh);
                    touched.push_back(byte_ptr);
                    byte_ptr++;
                end
            end
        end

        w.write_valid = 1'b0;
        w.byte_index  = '0;
        w.byte_value  = '0;
        w.status      = ST_OK;
        w.last        = 1'b0;
        foreach (touched[k])
        begin
            w.write_valid = 1'b1;
            w.byte_index  = 8'(touched[k]);
            w.byte_value  = image[touched[k]];
            words.push_back(w);
        end
        // nothing written: a single empty word carries the status
        if (words.size() == 0)
            words.push_back(w);
        words[words.size() - 1].status = st;
        words[words.size() - 1].last   = 1'b1;
        foreach (words[k])
            pending_writes.push_back(words[k]);
    endfunction

    function void compare_field(string what, logic [7:0] exp_val, logic [7:0] got_val);
        if (got_val !== exp_val)
        begin
            errors++;
            $display("%0t: %s expected %0h, got %0h", $time, what, exp_val, got_val);
        end
    endfunction

    function void check_write(logic [15:0] data, logic [2:0] user, logic tlast);
        write_word_t exp_word;
        if (pending_writes.size() == 0)
        begin
            errors++;
            $display({"%0t: result word with none expected, expected nothing, ",
                      "got tdata %h tuser %h tlast %b"},
                     $time, data, user, tlast);
        end
        else
        begin
            exp_word = pending_writes.pop_front();
            compare_field("write_valid", exp_word.write_valid, user[0]);
            compare_field("byte_index", exp_word.byte_index, data[7:0]);
            compare_field("byte_value", exp_word.byte_value, data[15:8]);
            compare_field("status", exp_word.status, user[2:1]);
            compare_field("last", exp_word.last, tlast);
        end
    endfunction
endclass

module tb_bit_byte_stream_packer_top;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam logic [63:0] PATTERN     = 64'h0123_4567_89AB_CDEF;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_data;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [71:0]        s_axis_tdata;   // value[63:0], item_count[67:64], zero pad
    logic [1:0]         s_axis_tuser;   // opcode[0], little_endian[1]
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [15:0]        m_axis_tdata;   // byte_index[7:0], byte_value[15:8]
    logic [2:0]         m_axis_tuser;   // write_valid[0], status[2:1]
    logic               m_axis_tlast;

    byte_write_tracker  tracker = new();
    bit                 no_gaps;
    int unsigned        words_seen;

    bit_byte_stream_packer_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic send_item(opcode_t op, logic [63:0] value, logic [3:0] cnt, logic le);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, cnt, value};
        s_axis_tuser  <= {le, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        tracker.predict_writes(op, value, cnt, le);
    endtask

    // Pad the bit position out to the next byte boundary
    task automatic align_to_byte();
        if (tracker.bit_ptr != 0)
            send_item(OP_BITS, {$urandom, $urandom}, 4'(8 - tracker.bit_ptr),
                      1'($urandom_range(0, 1)));
    endtask

    // Drain the block before touching the register
    task automatic set_capacity(int unsigned cap);
        s_axis_tvalid <= 1'b0;
        while (tracker.pending_writes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= CFG_W'(cap);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        tracker.capacity = cap;
    endtask

    task automatic send_random(int unsigned n);
        int unsigned  pick;
        logic [63:0]  value;
        repeat (n)
        begin
            pick  = $urandom_range(0, 99);
            value = {$urandom, $urandom};
            if (pick < 8)
                send_item(opcode_t'($urandom_range(0, 1)), value, 4'($urandom_range(9, 15)),
                          1'($urandom_range(0, 1)));
            else if (pick < 15)
                send_item(OP_BYTES, value, 4'($urandom_range(1, 8)), 1'($urandom_range(0, 1)));
            else if (pick < 40)
            begin
                align_to_byte();
                send_item(OP_BYTES, value,
                          ($urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 8))
                                                      : 4'($urandom_range(0, 2)),
                          1'($urandom_range(0, 1)));
            end
            else
                send_item(OP_BITS, value, 4'($urandom_range(0, 8)), 1'($urandom_range(0, 1)));
        end
    endtask

    // Result side: random gaps per word, one long hold-off to back the block up
    initial
    begin
        int unsigned gap_left;
        int unsigned hold_left;
        gap_left      = 0;
        hold_left     = 0;
        words_seen    = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                tracker.check_write(m_axis_tdata, m_axis_tuser, m_axis_tlast);
                words_seen++;
                gap_left = no_gaps ? 0 : $urandom_range(0, 3);
                if (words_seen == 80)
                    hold_left = 150;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int unsigned ph;
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        no_gaps       = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-byte capacity: misalignment, zero and oversize counts, overflow
        set_capacity(1);
        send_item(OP_BITS, 64'h5, 4'd3, 1'b0);
        send_item(OP_BYTES, '1, 4'd2, 1'b1);
        send_item(OP_BITS, '0, 4'd0, 1'b0);
        send_item(OP_BYTES, '0, 4'd0, 1'b1);
        send_item(OP_BITS, '1, 4'd15, 1'b1);
        send_item(OP_BYTES, '1, 4'd9, 1'b0);
        send_item(OP_BITS, '1, 4'd8, 1'b0);
        send_item(OP_BYTES, PATTERN, 4'd1, 1'b0);

        // full capacity: every byte order, unchanged byte, bits across a boundary
        set_capacity(256);
        send_item(OP_BYTES, PATTERN, 4'd8, 1'b1);
        send_item(OP_BYTES, PATTERN, 4'd8, 1'b0);
        send_item(OP_BYTES, PATTERN, 4'd3, 1'b1);
        send_item(OP_BYTES, PATTERN, 4'd4, 1'b1);
        send_item(OP_BYTES, PATTERN, 4'd2, 1'b1);
        send_item(OP_BYTES, PATTERN, 4'd1, 1'b1);
        send_item(OP_BYTES, PATTERN, 4'd6, 1'b1);
        send_item(OP_BYTES, ~PATTERN, 4'd5, 1'b0);
        send_item(OP_BITS, '0, 4'd8, 1'b0);
        send_item(OP_BITS, '1, 4'd3, 1'b0);
        send_item(OP_BITS, 64'hA5, 4'd8, 1'b1);

        for (ph = 0; ph < 6; ph++)
        begin
            no_gaps = (ph == 2);
            case (ph)
                1: set_capacity($urandom_range(1, 40));
                3:
                begin
                    // capacity just past the write position: partial writes in both modes
                    align_to_byte();
                    if (tracker.byte_ptr <= 254)
                    begin
                        set_capacity(tracker.byte_ptr + 2);
                        send_item(OP_BYTES, {$urandom, $urandom}, 4'd8, 1'b0);
                        send_item(OP_BITS, {$urandom, $urandom}, 4'd1, 1'b0);
                        set_capacity(tracker.byte_ptr + 1);
                        send_item(OP_BITS, {$urandom, $urandom}, 4'd3, 1'b0);
                        send_item(OP_BITS, '1, 4'd8, 1'b0);
                    end
                    set_capacity(256);
                end
                5: set_capacity($urandom_range(1, 256));
                default: set_capacity(256);
            endcase
            send_random((ph == 1) ? 15 : 28);
        end

        // run the buffer out to its last byte and beyond
        set_capacity(256);
        align_to_byte();
        while (tracker.byte_ptr < 256)
            send_item(OP_BYTES, {$urandom, $urandom}, 4'd8, 1'($urandom_range(0, 1)));
        send_item(OP_BITS, '1, 4'd8, 1'b0);
        send_item(OP_BYTES, '1, 4'd1, 1'b1);

        s_axis_tvalid <= 1'b0;
        while (tracker.pending_writes.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (tracker.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/bbsp_pkg.sv
rtl/core/bbsp_ctrl.sv
rtl/core/bbsp_dp.sv
rtl/core/bit_byte_stream_packer_top.sv
test/tb_bit_byte_stream_packer_top.sv
